// ===== hw/rtl/ptw_pkg.sv =====
// ----------------------------------------------------------------------------
// ptw_pkg: shared types and constants of the page table walker
// Memory geometry, command and status codes, walker states and helpers that
// form table word indexes from a table base and a virtual address.
// ----------------------------------------------------------------------------
package ptw_pkg;

    localparam int MEM_WORDS         = 8192;
    localparam int MEM_AW            = $clog2(MEM_WORDS);
    localparam int ENTRIES_PER_TABLE = 512;
    localparam int SLOT_W            = $clog2(ENTRIES_PER_TABLE);
    localparam int TBL_W             = 40;               // address bits 51:12
    localparam int WIDX_W            = TBL_W + SLOT_W;   // full word index
    localparam int ENTRY_W           = 64;
    localparam int VA_W              = 48;
    localparam int MIDX_W            = 13;

    localparam int PRESENT_BIT   = 0;
    localparam int PAGE_SIZE_BIT = 7;

    // Register index on the configuration port; registers sit 8 bytes apart.
    localparam logic REG_ROOT_TABLE = 1'b0;

    typedef logic [TBL_W-1:0]   tbl_t;
    typedef logic [WIDX_W-1:0]  widx_t;
    typedef logic [ENTRY_W-1:0] entry_t;
    typedef logic [VA_W-1:0]    va_t;

    typedef enum logic [1:0] {
        CMD_LOAD      = 2'd0,
        CMD_TRANSLATE = 2'd1,
        CMD_TEST      = 2'd2,
        CMD_CLEAR     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_NOT_PRESENT  = 2'd1,
        ST_OUT_OF_RANGE = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOKUP,
        S_WRITE,
        S_DONE
    } walk_state_t;

    typedef struct packed {
        status_t     status;
        logic [1:0]  level;
        entry_t      entry;
        entry_t      masked;
        logic        huge;
    } res_t;

    // Table slot of a virtual address at a given level.
    function automatic logic [SLOT_W-1:0] slot_of(input va_t va, input logic [1:0] lvl);
        logic [SLOT_W-1:0] s;
        case (lvl)
            2'd0:    s = va[47:39];
            2'd1:    s = va[38:30];
            2'd2:    s = va[29:21];
            default: s = va[20:12];
        endcase
        return s;
    endfunction

    // The table byte address has zero low bits, so the word index is the
    // table frame number followed by the slot.
    function automatic widx_t word_index(input tbl_t tbl, input logic [SLOT_W-1:0] slot);
        return {tbl, slot};
    endfunction

    function automatic logic in_memory(input widx_t widx);
        return widx < WIDX_W'(MEM_WORDS);
    endfunction

endpackage

// ===== hw/rtl/ptw_cfg.sv =====
// ----------------------------------------------------------------------------
// ptw_cfg: configuration register port
// APB-style slave that holds the root table address register.
// ----------------------------------------------------------------------------
module ptw_cfg
    import ptw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output tbl_t        root_tbl
);

    logic [51:0] root_reg;
    logic [51:0] root_next;
    logic        wr_root;

    assign pready  = 1'b1;
    assign wr_root = psel && penable && pwrite && (paddr[3] == REG_ROOT_TABLE);

    always_comb begin
        root_next = root_reg;
        if (wr_root) begin
            root_next = pwdata[51:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else begin
            root_reg <= root_next;
        end
    end

    assign prdata   = (paddr[3] == REG_ROOT_TABLE) ? {12'b0, root_reg} : 64'b0;
    assign root_tbl = root_reg[51:12];

endmodule

// ===== hw/rtl/ptw_walker.sv =====
// ----------------------------------------------------------------------------
// ptw_walker: table memory and walk sequencer
// Holds the table memory, walks it one level per cycle with a registered
// read, writes back cleared entries and keeps the result in an output register.
// ----------------------------------------------------------------------------
module ptw_walker
    import ptw_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  tbl_t        root_tbl,
    input  logic        s_valid,
    output logic        s_ready,
    input  cmd_t        s_cmd,
    input  va_t         s_va,
    input  entry_t      s_mask,
    input  logic [MIDX_W-1:0] s_idx,
    input  entry_t      s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output res_t        m_res
);

    entry_t mem [MEM_WORDS];

    walk_state_t state_reg, state_next;
    cmd_t        cmd_reg;
    va_t         va_reg;
    entry_t      mask_reg;
    logic [1:0]  level_reg, level_next;
    logic [MEM_AW-1:0] widx_reg, widx_next;
    entry_t      rd_data_reg;
    res_t        res_reg, res_next;
    logic        out_valid_reg;
    res_t        out_reg;

    logic              accept;
    logic              mem_we;
    logic [MEM_AW-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic              rd_en;
    logic              out_load;
    logic              load_in_range;

    // Index of the next table word, either from the root or from the entry
    // just read.
    tbl_t       walk_tbl;
    va_t        walk_va;
    logic [1:0] walk_lvl;
    widx_t      walk_widx;
    logic       walk_oob;

    logic not_present;
    logic is_huge;
    logic is_final;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;
    assign load_in_range = 32'(s_idx) < 32'(MEM_WORDS);

    assign walk_tbl  = (state_reg == S_IDLE) ? root_tbl : rd_data_reg[51:12];
    assign walk_va   = (state_reg == S_IDLE) ? s_va : va_reg;
    assign walk_lvl  = (state_reg == S_IDLE) ? 2'd0 : level_reg + 2'd1;
    assign walk_widx = word_index(walk_tbl, slot_of(walk_va, walk_lvl));
    assign walk_oob  = !in_memory(walk_widx);

    assign not_present = !rd_data_reg[PRESENT_BIT];
    assign is_huge     = (level_reg == 2'd2) && rd_data_reg[PAGE_SIZE_BIT];
    assign is_final    = (level_reg == 2'd3) || is_huge;

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || m_ready);

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_LOAD || walk_oob) begin
                        state_next = S_DONE;
                    end else begin
                        state_next = S_LOOKUP;
                    end
                end
            end
            S_LOOKUP: begin
                if (not_present) begin
                    state_next = S_DONE;
                end else if (is_final) begin
                    state_next = (cmd_reg == CMD_CLEAR) ? S_WRITE : S_DONE;
                end else if (walk_oob) begin
                    state_next = S_DONE;
                end
            end
            S_WRITE: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Memory accesses and result for each state.
    always_comb begin
        mem_we     = 1'b0;
        mem_waddr  = widx_reg;
        mem_wdata  = res_reg.entry & ~mask_reg;
        rd_en      = 1'b0;
        widx_next  = widx_reg;
        level_next = level_reg;
        res_next   = res_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_cmd == CMD_LOAD) begin
                        mem_we    = load_in_range;
                        mem_waddr = MEM_AW'(s_idx);
                        mem_wdata = s_data;
                        res_next  = '{ST_OK, 2'd0, '0, '0, 1'b0};
                    end else if (walk_oob) begin
                        res_next = '{ST_OUT_OF_RANGE, 2'd0, '0, '0, 1'b0};
                    end else begin
                        rd_en      = 1'b1;
                        widx_next  = walk_widx[MEM_AW-1:0];
                        level_next = 2'd0;
                    end
                end
            end
            S_LOOKUP: begin
                if (not_present) begin
                    res_next = '{ST_NOT_PRESENT, level_reg, '0, '0, 1'b0};
                end else if (is_final) begin
                    res_next = '{ST_OK, 2'd0, rd_data_reg, rd_data_reg & mask_reg, is_huge};
                end else if (walk_oob) begin
                    res_next = '{ST_OUT_OF_RANGE, walk_lvl, '0, '0, 1'b0};
                end else begin
                    rd_en      = 1'b1;
                    widx_next  = walk_widx[MEM_AW-1:0];
                    level_next = walk_lvl;
                end
            end
            S_WRITE: begin
                mem_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[widx_next];
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            cmd_reg  <= s_cmd;
            va_reg   <= s_va;
            mask_reg <= s_mask;
        end
        widx_reg  <= widx_next;
        level_reg <= level_next;
        res_reg   <= res_next;
        if (out_load) begin
            out_reg <= res_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_reg;

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_res.status == ST_OK || m_res.status == ST_NOT_PRESENT ||
                     m_res.status == ST_OUT_OF_RANGE))
        else $error("result carries an undefined status code");

    a_huge_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_res.huge) |-> (m_res.status == ST_OK && m_res.level == 2'd0))
        else $error("huge page flagged on a faulted walk");

    a_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> ((state_reg == S_IDLE && accept && s_cmd == CMD_LOAD) ||
                    (state_reg == S_WRITE && cmd_reg == CMD_CLEAR)))
        else $error("table memory written outside a load or a clear");

    a_write_then_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |=> (state_reg == S_DONE))
        else $error("write-back did not hand over to the result stage");

    a_clear_path: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WRITE) |-> ($past(state_reg) == S_LOOKUP))
        else $error("write-back entered without a finished lookup");

endmodule

// ===== hw/rtl/page_table_walker_ad_bits.sv =====
// ----------------------------------------------------------------------------
// page_table_walker_ad_bits: four-level page table walker with bit test/clear
// Stores table words, walks the four-level tables for a virtual address and
// returns, tests or clears bits of the final entry.
// ----------------------------------------------------------------------------
//  Channel   Direction  Word
//  s_*       in         tuser: command; tdata: virt_addr, bit_mask, mem_index, mem_data
//  m_*       out        tuser: status; tdata: fault_level, final_entry, masked_bits, huge_page
//  APB       in/out     root_table_addr at byte address 0
//
// A load goes from acceptance through the done state into the result register.
// A walk reads one table level per cycle (0 to 4 levels, none when the root
// table lies outside the memory), and a clear adds a write-back of the final
// entry; the table memory's registered read and the dependent level-by-level
// reads set this pace. The next word is accepted the cycle after a result
// moves into the output register, even while that result still waits on
// m_tready. Reset is synchronous, active low; it clears the sequencer and the
// root register, not the table memory.
module page_table_walker_ad_bits
    import ptw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [191:0] s_tdata,   // virt_addr[47:0], bit_mask[111:48],
                                    // mem_index[124:112], mem_data[188:125], zero fill
    input  logic [1:0]   s_tuser,   // command[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // fault_level[1:0], final_entry[65:2],
                                    // masked_bits[129:66], huge_page[130], zero fill
    output logic [1:0]   m_tuser,   // status[1:0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    tbl_t root_tbl;
    res_t m_res;

    ptw_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .root_tbl (root_tbl)
    );

    ptw_walker u_walker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .root_tbl (root_tbl),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .s_cmd    (cmd_t'(s_tuser)),
        .s_va     (s_tdata[47:0]),
        .s_mask   (s_tdata[111:48]),
        .s_idx    (s_tdata[124:112]),
        .s_data   (s_tdata[188:125]),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_res    (m_res)
    );

    assign m_tuser = m_res.status;
    assign m_tdata = {5'b0, m_res.huge, m_res.masked, m_res.entry, m_res.level};

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the four-level page table walker
// Builds page tables in the walker's memory through load words, then walks,
// tests and clears entry bits. A predictor in this file keeps its own copy of
// the table memory and root address, and every result word is compared with
// the prediction, field by field, under random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ptw_pkg::*;

    localparam int          LIMIT_CYCLES  = 400_000;
    localparam int          WALK_CYCLES   = 8;
    localparam int          PHASE_WORDS   = 135;
    localparam logic [3:0]  ROOT_REG_ADDR = {REG_ROOT_TABLE, 3'b000};

    typedef struct {
        status_t    status;
        logic [1:0] level;
        entry_t     entry;
        entry_t     masked;
        logic       huge;
    } walk_result_t;

    typedef enum {
        ENT_NEXT,
        ENT_LEAF,
        ENT_HUGE,
        ENT_ABSENT,
        ENT_FAR
    } entry_kind_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;   // virt_addr, bit_mask, mem_index, mem_data, zero fill
    logic [1:0]   s_tuser;   // command
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // fault_level, final_entry, masked_bits, huge_page, zero fill
    logic [1:0]   m_tuser;   // status
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [3:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    entry_t       table_copy   [MEM_WORDS];
    bit           word_written [MEM_WORDS];
    logic [51:0]  root_addr;
    walk_result_t expected_q [$];

    int           send_idle_pct;
    int           recv_stall_pct;
    int           hold_left;
    int           items_sent;
    int           mismatches;
    int unsigned  cycle_count;

    page_table_walker_ad_bits dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        $display("%0t ns: %s mismatch, got %h, expected %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [8:0] table_slot(input va_t va, input int lvl);
        return 9'(va >> (39 - 9 * lvl));
    endfunction

    function automatic walk_result_t walk_tables(input cmd_t cmd, input va_t va,
                                                 input entry_t mask);
        walk_result_t r;
        logic [39:0]  frame;
        logic [48:0]  where;
        entry_t       e;
        bit           stop;
        r.status = ST_OK;
        r.level  = 2'd0;
        r.entry  = '0;
        r.masked = '0;
        r.huge   = 1'b0;
        e        = '0;
        where    = '0;
        stop     = 1'b0;
        frame    = root_addr[51:12];
        for (int lvl = 0; lvl < 4 && !stop; lvl++) begin
            where = {frame, table_slot(va, lvl)};
            if (where >= 49'(MEM_WORDS)) begin
                r.status = ST_OUT_OF_RANGE;
                r.level  = 2'(lvl);
                return r;
            end
            e = table_copy[where[12:0]];
            if (!e[PRESENT_BIT]) begin
                r.status = ST_NOT_PRESENT;
                r.level  = 2'(lvl);
                return r;
            end
            if (lvl == 2 && e[PAGE_SIZE_BIT]) begin
                r.huge = 1'b1;
                stop   = 1'b1;
            end
            frame = e[51:12];
        end
        if (cmd == CMD_CLEAR)
            table_copy[where[12:0]] = e & ~mask;
        r.entry  = e;
        r.masked = e & mask;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Streams and register port
    // ------------------------------------------------------------------------
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin : check_results
        walk_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result word", {62'd0, m_tuser}, 64'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", 64'(m_tuser), 64'(want.status));
                if (m_tdata[1:0] !== want.level)
                    report_mismatch("fault_level", 64'(m_tdata[1:0]), 64'(want.level));
                if (m_tdata[65:2] !== want.entry)
                    report_mismatch("final_entry", m_tdata[65:2], want.entry);
                if (m_tdata[129:66] !== want.masked)
                    report_mismatch("masked_bits", m_tdata[129:66], want.masked);
                if (m_tdata[130] !== want.huge)
                    report_mismatch("huge_page", 64'(m_tdata[130]), 64'(want.huge));
            end
        end
    end

    task automatic send_word(input cmd_t cmd, input va_t va, input entry_t mask,
                             input logic [12:0] idx, input entry_t data);
        walk_result_t load_done;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {3'b000, data, idx, mask, va};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
        if (cmd == CMD_LOAD) begin
            table_copy[idx]   = data;
            word_written[idx] = 1'b1;
            load_done.status  = ST_OK;
            load_done.level   = 2'd0;
            load_done.entry   = '0;
            load_done.masked  = '0;
            load_done.huge    = 1'b0;
            expected_q.push_back(load_done);
        end else begin
            expected_q.push_back(walk_tables(cmd, va, mask));
        end
    endtask

    // The sender drops its valid first so that no word is offered twice.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    task automatic write_root(input logic [51:0] value);
        logic [63:0] got;
        drain_results();
        repeat (WALK_CYCLES) @(posedge aclk);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ROOT_REG_ADDR;
        pwdata  <= 64'(value);
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        root_addr = value;
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        got = prdata;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== 64'(value))
            report_mismatch("root_table_addr readback", got, 64'(value));
    endtask

    // ------------------------------------------------------------------------
    // Table builders
    // ------------------------------------------------------------------------
    function automatic entry_t make_entry(input int lvl, input entry_kind_t kind);
        entry_t e;
        e = {$urandom, $urandom};
        case (kind)
            ENT_NEXT: begin
                e[51:12]       = 40'($urandom_range(15));
                e[PRESENT_BIT] = 1'b1;
                if (lvl == 2)
                    e[PAGE_SIZE_BIT] = 1'b0;
            end
            ENT_FAR: begin
                // The next table starts at or past the end of the memory.
                case ($urandom_range(2))
                    0:       e[51:12] = 40'd16;
                    1:       e[51:12] = '1;
                    default: e[51:12] = {8'($urandom) | 8'h01, 32'($urandom)};
                endcase
                e[PRESENT_BIT] = 1'b1;
                if (lvl == 2)
                    e[PAGE_SIZE_BIT] = 1'b0;
            end
            ENT_HUGE: begin
                e[PRESENT_BIT]   = 1'b1;
                e[PAGE_SIZE_BIT] = 1'b1;
            end
            ENT_LEAF: e[PRESENT_BIT] = 1'b1;
            default:  e[PRESENT_BIT] = 1'b0;
        endcase
        return e;
    endfunction

    function automatic entry_t pick_mask();
        entry_t m;
        case ($urandom_range(4))
            0:       m = {$urandom, $urandom};
            1:       m = 64'($urandom_range(1, 3)) << 5;   // accessed and dirty
            2:       m = 64'd1 << $urandom_range(63);
            3:       m = '1;
            default: m = '0;
        endcase
        return m;
    endfunction

    function automatic cmd_t pick_walk_cmd();
        case ($urandom_range(2))
            0:       return CMD_TRANSLATE;
            1:       return CMD_TEST;
            default: return CMD_CLEAR;
        endcase
    endfunction

    function automatic va_t pick_va();
        return va_t'({$urandom, $urandom});
    endfunction

    task automatic load_word(input logic [12:0] idx, input entry_t data);
        send_word(CMD_LOAD, pick_va(), {$urandom, $urandom}, idx, data);
    endtask

    // Loads every table word the walk would read that holds nothing yet.
    task automatic fill_path(input va_t va);
        logic [39:0] frame;
        logic [48:0] where;
        entry_t      e;
        int          pick;
        entry_kind_t kind;
        frame = root_addr[51:12];
        for (int lvl = 0; lvl < 4; lvl++) begin
            where = {frame, table_slot(va, lvl)};
            if (where >= 49'(MEM_WORDS))
                return;
            if (!word_written[where[12:0]]) begin
                pick = $urandom_range(99);
                if (pick < 70)
                    kind = ENT_NEXT;
                else if (pick < 82)
                    kind = ENT_ABSENT;
                else if (pick < 92)
                    kind = ENT_FAR;
                else
                    kind = ENT_HUGE;
                load_word(where[12:0], make_entry(lvl, kind));
            end
            e = table_copy[where[12:0]];
            if (!e[PRESENT_BIT] || (lvl == 2 && e[PAGE_SIZE_BIT]))
                return;
            frame = e[51:12];
        end
    endtask

    // Writes a whole path for the address, ending in a chosen way.
    task automatic build_walk(input va_t va);
        entry_kind_t end_kind;
        int          stop_lvl;
        int          pick;
        logic [39:0] frame;
        logic [48:0] where;
        pick = $urandom_range(99);
        if (pick < 55) begin
            end_kind = ENT_LEAF;
            stop_lvl = 3;
        end else if (pick < 70) begin
            end_kind = ENT_HUGE;
            stop_lvl = 2;
        end else if (pick < 85) begin
            end_kind = ENT_ABSENT;
            stop_lvl = $urandom_range(3);
        end else begin
            end_kind = ENT_FAR;
            stop_lvl = $urandom_range(2);
        end
        frame = root_addr[51:12];
        for (int lvl = 0; lvl <= stop_lvl; lvl++) begin
            where = {frame, table_slot(va, lvl)};
            if (where >= 49'(MEM_WORDS))
                return;
            load_word(where[12:0], make_entry(lvl, (lvl == stop_lvl) ? end_kind : ENT_NEXT));
            frame = table_copy[where[12:0]][51:12];
        end
    endtask

    task automatic walk(input cmd_t cmd, input va_t va, input entry_t mask);
        fill_path(va);
        send_word(cmd, va, mask, 13'($urandom), {$urandom, $urandom});
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Root is zero after reset; the all-ones address uses slot 511 at every level.
    task automatic test_directed();
        va_t top_va;
        top_va = '1;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        load_word(13'd511,  64'h8000_0000_0000_1081);
        load_word(13'd1023, 64'h0000_0000_0000_2081);   // page size at level 1 is ignored
        load_word(13'd1535, 64'h0000_0000_0000_3061);
        load_word(13'd2047, '1);
        walk(CMD_TRANSLATE, top_va, '0);
        walk(CMD_TEST,      top_va, '1);
        walk(CMD_CLEAR,     top_va, 64'h60);
        walk(CMD_TRANSLATE, top_va, '1);
        walk(CMD_CLEAR,     top_va, '1);
        walk(CMD_TRANSLATE, top_va, '1);                // leaf now absent
        load_word(13'd1535, 64'h0000_0000_0000_3081);   // huge page
        walk(CMD_TEST,      top_va, 64'h80);
        walk(CMD_CLEAR,     top_va, 64'h1);
        walk(CMD_TRANSLATE, top_va, '1);
        load_word(13'd1023, 64'hFFFF_FFFF_FFFF_FFFE);
        walk(CMD_TRANSLATE, top_va, '1);
        load_word(13'd1023, 64'h0000_0000_0001_0001);   // level-2 table past memory
        walk(CMD_TEST,      top_va, '1);
        load_word(13'd1023, 64'h0000_0000_0000_2001);
        load_word(13'd1535, 64'h0000_0000_0001_0001);   // level-3 table past memory
        walk(CMD_TRANSLATE, top_va, '1);
        load_word(13'd0,    '0);
        walk(CMD_CLEAR,     '0, '1);
        load_word(13'd8191, '0);
        drain_results();
    endtask

    task automatic test_root_extremes();
        va_t va;
        write_root('1);
        walk(CMD_TRANSLATE, '1, '1);
        walk(CMD_CLEAR, '0, '1);
        write_root({40'd16, 12'h000});   // first frame past the memory
        walk(CMD_TEST, '0, '1);
        write_root({40'd15, 12'hFFF});   // last frame, low bits ignored
        repeat (4) begin
            va = pick_va();
            build_walk(va);
            walk(pick_walk_cmd(), va, pick_mask());
        end
        write_root('0);
    endtask

    task automatic test_random_phases();
        int   idle_plan  [4] = '{0, 66, 0, 21};
        int   stall_plan [4] = '{0, 0, 66, 21};
        int   stop_at;
        int   pick;
        va_t  va;
        for (int p = 0; p < 4; p++) begin
            write_root({40'($urandom_range(15)), 12'($urandom)});
            send_idle_pct  = idle_plan[p];
            recv_stall_pct = stall_plan[p];
            stop_at = items_sent + PHASE_WORDS;
            while (items_sent < stop_at) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    va = pick_va();
                    build_walk(va);
                    repeat ($urandom_range(1, 3))
                        walk(pick_walk_cmd(), va, pick_mask());
                    // A neighbor reads the same upper-level entries and another slot of the same last-level table.
                    if ($urandom_range(3) == 0)
                        walk(pick_walk_cmd(), {va[47:21], 21'($urandom)}, pick_mask());
                end else if (pick < 92) begin
                    walk(pick_walk_cmd(), pick_va(), pick_mask());
                end else begin
                    load_word(13'($urandom), {$urandom, $urandom});
                end
            end
        end
    endtask

    task automatic test_output_stall();
        va_t va;
        drain_results();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 400;
        repeat (10) begin
            va = pick_va();
            build_walk(va);
            walk(pick_walk_cmd(), va, pick_mask());
        end
        drain_results();
        send_idle_pct  = 21;
        recv_stall_pct = 21;
        repeat (6) begin
            va = pick_va();
            build_walk(va);
            walk(pick_walk_cmd(), va, pick_mask());
        end
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = CMD_LOAD;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = ROOT_REG_ADDR;
        pwdata         = '0;
        root_addr      = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        items_sent     = 0;
        mismatches     = 0;
        cycle_count    = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_root_extremes();
        test_random_phases();
        test_output_stall();

        drain_results();
        repeat (2 * WALK_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ptw_pkg.sv
hw/rtl/ptw_cfg.sv
hw/rtl/ptw_walker.sv
hw/rtl/page_table_walker_ad_bits.sv
tb/tb_top.sv
